### hdl/bm3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bm3_pkg;

  // Fixed field widths of the result channel and the configuration port.
  localparam int unsigned OUT_ROW_W  = 12;
  localparam int unsigned OUT_COL_W  = 10;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  // Depth of the queue between the front and the back part.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Window positions that survive a shift to the right (columns 0 and 1 of each row).
  localparam logic [8:0] KEEP_LEFT_COLS = 9'h0DB;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH      = 2'd0,
    CFG_IMAGE_HEIGHT     = 2'd1,
    CFG_OPERATION        = 2'd2,
    CFG_STRUCTURING_MASK = 2'd3
  } bm3_cfg_idx_e;

  localparam logic OP_DILATE = 1'b0;
  localparam logic OP_ERODE  = 1'b1;

  typedef struct packed {
    logic [10:0] image_width;
    logic [12:0] image_height;
    logic        operation;
    logic [8:0]  structuring_mask;
  } bm3_cfg_t;

  localparam bm3_cfg_t CFG_RESET = '{
    image_width:      11'd640,
    image_height:     13'd480,
    operation:        OP_DILATE,
    structuring_mask: 9'd186
  };

  // Emission slots of one pixel; results leave from the lowest field up (prev_row_left first).
  typedef struct packed {
    logic last_row_end;  // last row, right border pixel
    logic last_row_left; // last row, pixel one column back
    logic prev_row_end;  // row above, right border pixel
    logic prev_row_left; // row above, pixel one column back
  } bm3_emit_t;

  // One classified pixel as it travels from the front to the back part.
  typedef struct packed {
    logic [8:0]           window;
    bm3_emit_t            emit;
    logic [OUT_ROW_W-1:0] row_prev;
    logic [OUT_ROW_W-1:0] row_cur;
    logic [OUT_COL_W-1:0] col_prev;
    logic [OUT_COL_W-1:0] col_cur;
  } bm3_item_t;

  // Dilation is the OR and erosion the AND of the neighbours the mask selects.
  function automatic logic bm3_apply(logic [8:0] win, logic [8:0] mask, logic op);
    logic [8:0] sel;
    sel = win & mask;
    if (op == OP_ERODE) begin
      return sel == mask;
    end
    return |sel;
  endfunction

endpackage

`default_nettype wire

### hdl/bm3_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input pixel channel.
interface bm3_pixel_if;
  logic valid;
  logic ready;
  logic pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

// Result channel.
interface bm3_result_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic        out_pixel;
  logic        run_last;
  logic        frame_last;

  modport source (
    output valid, output out_row, output out_col, output out_pixel,
    output run_last, output frame_last, input ready
  );
  modport sink (
    input valid, input out_row, input out_col, input out_pixel,
    input run_last, input frame_last, output ready
  );
endinterface

`default_nettype wire

### hdl/bm3_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bm3_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### hdl/bm3_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bm3_queue
  import bm3_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  output logic           push_ready_o,
  input  wire bm3_item_t push_item_i,
  output logic           pop_valid_o,
  input  wire logic      pop_ready_i,
  output bm3_item_t      pop_item_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  bm3_item_t         entry_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]     count_q, count_d;
  logic              push, pop;

  assign push_ready_o = count_q != NW'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + NW'(1);
    end else if (pop && !push) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

### hdl/bm3_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bm3_front
  import bm3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire bm3_cfg_t cfg_i,
  bm3_pixel_if.sink     pix_if,
  output logic          push_valid_o,
  input  wire logic     push_ready_i,
  output bm3_item_t     push_item_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] w_last, a_col;
  logic [RW-1:0] h_last;
  logic          a_row_end, a_last_row, accept;

  // Second stage: the line store read is in flight.
  logic                 b_valid_q, b_valid_d;
  logic [CW-1:0]        b_col_q;
  logic                 b_col_first_q, b_row_ge1_q, b_row_ge2_q;
  logic                 b_row_end_q, b_last_row_q, b_pix_q;
  logic [OUT_ROW_W-1:0] b_row_prev_q, b_row_cur_q;
  logic [OUT_COL_W-1:0] b_col_prev_q, b_col_cur_q;
  logic                 b_fwd_q;
  logic [1:0]           b_fwd_data_q;
  logic                 b_fire;

  logic [1:0] ram_rd_data, line_bits;
  logic       top_bit, mid_bit;
  logic [8:0] win_q, win_d;

  // Effective last column and last row after clamping to the supported range.
  always_comb begin
    if (cfg_i.image_width == '0) begin
      w_last = '0;
    end else if (32'(cfg_i.image_width) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(cfg_i.image_width - 11'd1);
    end
    if (cfg_i.image_height == '0) begin
      h_last = '0;
    end else if (32'(cfg_i.image_height) > MAX_HEIGHT) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(cfg_i.image_height - 13'd1);
    end
  end

  assign a_row_end  = col_q >= w_last;
  assign a_col      = a_row_end ? w_last : col_q;
  assign a_last_row = row_q >= h_last;

  assign b_fire       = b_valid_q && push_ready_i;
  assign pix_if.ready = !b_valid_q || push_ready_i;
  assign accept       = pix_if.valid && pix_if.ready;

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    b_valid_d = b_valid_q;
    if (b_fire) begin
      b_valid_d = 1'b0;
    end
    if (accept) begin
      b_valid_d = 1'b1;
      if (a_row_end) begin
        col_d = '0;
        row_d = a_last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      b_valid_q <= 1'b0;
      win_q     <= '0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      b_valid_q <= b_valid_d;
      win_q     <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_col_q       <= a_col;
      b_col_first_q <= a_col == '0;
      b_row_ge1_q   <= row_q != '0;
      b_row_ge2_q   <= row_q > RW'(1);
      b_row_end_q   <= a_row_end;
      b_last_row_q  <= a_last_row;
      b_pix_q       <= pix_if.pixel_in;
      b_row_prev_q  <= OUT_ROW_W'(row_q - RW'(1));
      b_row_cur_q   <= OUT_ROW_W'(row_q);
      b_col_prev_q  <= OUT_COL_W'(a_col - CW'(1));
      b_col_cur_q   <= OUT_COL_W'(a_col);
      // The older pixel's write lands in the same cycle as this read.
      b_fwd_q       <= b_fire && (b_col_q == a_col);
      b_fwd_data_q  <= {line_bits[0], b_pix_q};
    end
  end

  // Bit 1 holds the row two above, bit 0 the row above.
  bm3_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk_i     (clk_i),
    .wr_en_i   (b_fire),
    .wr_addr_i (b_col_q),
    .wr_data_i ({line_bits[0], b_pix_q}),
    .rd_en_i   (accept),
    .rd_addr_i (a_col),
    .rd_data_o (ram_rd_data)
  );

  assign line_bits = b_fwd_q ? b_fwd_data_q : ram_rd_data;
  assign top_bit   = b_row_ge2_q && line_bits[1];
  assign mid_bit   = b_row_ge1_q && line_bits[0];

  always_comb begin
    win_d = win_q;
    if (b_fire) begin
      win_d = (b_col_first_q ? 9'd0 : ({1'b0, win_q[8:1]} & KEEP_LEFT_COLS))
            | {b_pix_q, 2'b00, mid_bit, 2'b00, top_bit, 2'b00};
    end
  end

  assign push_valid_o                     = b_valid_q;
  assign push_item_o.window               = (b_col_first_q ? 9'd0
                                            : ({1'b0, win_q[8:1]} & KEEP_LEFT_COLS))
                                            | {b_pix_q, 2'b00, mid_bit, 2'b00, top_bit, 2'b00};
  assign push_item_o.emit.prev_row_left   = b_row_ge1_q && !b_col_first_q;
  assign push_item_o.emit.prev_row_end    = b_row_ge1_q && b_row_end_q;
  assign push_item_o.emit.last_row_left   = b_last_row_q && !b_col_first_q;
  assign push_item_o.emit.last_row_end    = b_last_row_q && b_row_end_q;
  assign push_item_o.row_prev             = b_row_prev_q;
  assign push_item_o.row_cur              = b_row_cur_q;
  assign push_item_o.col_prev             = b_col_prev_q;
  assign push_item_o.col_cur              = b_col_cur_q;

  // A stalled pixel keeps its column, so the line store write address holds.
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !push_ready_i |=> b_valid_q && $stable(b_col_q))
    else $error("stalled pixel lost its place in the second stage");

  // Every accepted pixel reaches the second stage.
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> b_valid_q)
    else $error("accepted pixel did not reach the second stage");

endmodule

`default_nettype wire

### hdl/bm3_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bm3_back
  import bm3_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire bm3_cfg_t  cfg_i,
  input  wire logic      head_valid_i,
  input  wire bm3_item_t head_item_i,
  output logic           pop_o,
  bm3_result_if.source   res_if
);

  logic [3:0] done_q, done_d;
  logic [3:0] rem, sel;
  logic       single, out_free, load;
  logic [8:0] win, win_shift, win_up, win_up_shift, sel_win;
  logic [OUT_ROW_W-1:0] sel_row;
  logic [OUT_COL_W-1:0] sel_col;

  logic                 ov_q, ov_d;
  logic [OUT_ROW_W-1:0] row_q;
  logic [OUT_COL_W-1:0] col_q;
  logic                 pixel_q, run_last_q, frame_last_q;

  assign rem      = head_item_i.emit & ~done_q;
  assign sel      = rem & (~rem + 4'd1);
  assign single   = (rem & (rem - 4'd1)) == 4'd0;
  assign out_free = !ov_q || res_if.ready;
  assign load     = head_valid_i && (rem != 4'd0) && out_free;
  // A pixel with nothing to emit leaves the queue at once.
  assign pop_o    = head_valid_i && ((rem == 4'd0) || (load && single));

  assign win          = head_item_i.window;
  assign win_shift    = {1'b0, win[8:1]} & KEEP_LEFT_COLS;
  assign win_up       = {3'b000, win[8:3]};
  assign win_up_shift = {1'b0, win_up[8:1]} & KEEP_LEFT_COLS;

  always_comb begin
    if (sel[0]) begin
      sel_win = win;
      sel_row = head_item_i.row_prev;
      sel_col = head_item_i.col_prev;
    end else if (sel[1]) begin
      sel_win = win_shift;
      sel_row = head_item_i.row_prev;
      sel_col = head_item_i.col_cur;
    end else if (sel[2]) begin
      sel_win = win_up;
      sel_row = head_item_i.row_cur;
      sel_col = head_item_i.col_prev;
    end else begin
      sel_win = win_up_shift;
      sel_row = head_item_i.row_cur;
      sel_col = head_item_i.col_cur;
    end
  end

  always_comb begin
    done_d = done_q;
    ov_d   = ov_q;
    if (res_if.ready) begin
      ov_d = 1'b0;
    end
    if (load) begin
      ov_d   = 1'b1;
      done_d = done_q | sel;
    end
    if (pop_o) begin
      done_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      done_q <= done_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      row_q        <= sel_row;
      col_q        <= sel_col;
      pixel_q      <= bm3_apply(sel_win, cfg_i.structuring_mask, cfg_i.operation);
      run_last_q   <= single;
      frame_last_q <= sel[3];
    end
  end

  assign res_if.valid      = ov_q;
  assign res_if.out_row    = row_q;
  assign res_if.out_col    = col_q;
  assign res_if.out_pixel  = pixel_q;
  assign res_if.run_last   = run_last_q;
  assign res_if.frame_last = frame_last_q;

  // The end of the image is always the last result of its pixel.
  a_frame_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && frame_last_q |-> run_last_q)
    else $error("frame end without run end");

  // The progress mask only marks slots the head pixel really has.
  a_done_subset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (done_q & ~head_item_i.emit) == 4'd0)
    else $error("progress mask out of step with queue head");

  // A new head starts with no slot done.
  a_pop_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> done_q == 4'd0)
    else $error("progress mask not cleared after pop");

endmodule

`default_nettype wire

### hdl/binary_morphology_3x3.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake         Payload
// pix_if    in         valid / ready     pixel_in (1 bit, raster order)
// res_if    out        valid / ready     out_row, out_col, out_pixel, run_last, frame_last
// cfg       in         cfg_we_i (write)  cfg_idx_i, cfg_data_i
//
// A pixel is taken every cycle while the queue has room, and results flow out one per
// cycle while res_if is ready; during the last row most pixels give two results, so that
// row runs slower. Results leave through a single output register.
// The line stores sit in one 2-bit wide RAM read at accept and written when the pixel
// leaves the second stage, which waits while the queue is full.
// Reset clears counters, window and handshake state; the line stores are not cleared.
// A stalled result channel fills the two-entry queue before the pixel input stalls.

module binary_morphology_3x3
  import bm3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  bm3_pixel_if.sink                  pix_if,
  bm3_result_if.source               res_if,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  bm3_cfg_t  cfg_q, cfg_d;
  logic      push_valid, push_ready, head_valid, pop;
  bm3_item_t push_item, head_item;

  // Configuration registers; writes are only expected while the block is idle.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (bm3_cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:      cfg_d.image_width      = cfg_data_i[10:0];
        CFG_IMAGE_HEIGHT:     cfg_d.image_height     = cfg_data_i[12:0];
        CFG_OPERATION:        cfg_d.operation        = cfg_data_i[0];
        CFG_STRUCTURING_MASK: cfg_d.structuring_mask = cfg_data_i[8:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front part: counts position, keeps the line stores and the window, and
  // classifies each pixel by the results it will cause.
  bm3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pix_if       (pix_if),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // The queue lets the front keep taking pixels while the back drains results.
  bm3_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (pop),
    .pop_item_o   (head_item)
  );

  // Back part: issues each pixel's results one transaction at a time.
  bm3_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_item_i  (head_item),
    .pop_o        (pop),
    .res_if       (res_if)
  );

endmodule

`default_nettype wire

### tb/bm3_morph_checker.sv
`timescale 1ns / 1ps

// Watches the pixel, result and register channels of the 3x3 morphology block.
// It keeps its own copy of the registers, line stores and window, works out
// the results that each accepted pixel gives, and compares every accepted
// result with the oldest one still owed.
module bm3_morph_checker
  import bm3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bm3_pixel_if                  pix_if,
  bm3_result_if                 res_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  typedef struct packed {
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 px;
    logic                 run_last;
    logic                 frame_last;
  } morph_result_t;

  logic [10:0] cfg_width;
  logic [12:0] cfg_height;
  logic        cfg_op;
  logic [8:0]  cfg_mask;

  bit          line_old [MAX_WIDTH];
  bit          line_new [MAX_WIDTH];
  logic [8:0]  win;
  int unsigned col_cnt;
  int unsigned row_cnt;

  morph_result_t owed_results [$];

  // OR of the selected neighbours for dilation, AND of them for erosion.
  function automatic logic morph_value(logic [8:0] w);
    logic [8:0] hit;
    hit = w & cfg_mask;
    if (cfg_op == OP_ERODE) begin
      return hit == cfg_mask;
    end
    return hit != 9'd0;
  endfunction

  function automatic morph_result_t make_result(int unsigned row, int unsigned col,
                                                logic [8:0] w);
    morph_result_t res;
    res.row        = row[OUT_ROW_W-1:0];
    res.col        = col[OUT_COL_W-1:0];
    res.px         = morph_value(w);
    res.run_last   = 1'b0;
    res.frame_last = 1'b0;
    return res;
  endfunction

  task automatic morph_pixel(input logic px);
    int unsigned   w;
    int unsigned   h;
    int unsigned   c;
    int unsigned   r;
    logic          top;
    logic          mid;
    logic          row_end;
    logic          last_row;
    logic [8:0]    up;
    morph_result_t batch [$];
    w = cfg_width;
    h = cfg_height;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    c = col_cnt;
    r = row_cnt;
    // A count left beyond a shrunken width is taken as the end of the row.
    if (c >= w) c = w - 1;
    row_end  = (c >= w - 1);
    last_row = (r >= h - 1);
    top = (r >= 2) ? line_old[c] : 1'b0;
    mid = (r >= 1) ? line_new[c] : 1'b0;
    line_old[c] = line_new[c];
    line_new[c] = px;
    if (c == 0) win = '0;
    win = ((win >> 1) & KEEP_LEFT_COLS) | {px, 2'b00, mid, 2'b00, top, 2'b00};
    if (r >= 1) begin
      if (c >= 1) batch.push_back(make_result(r - 1, c - 1, win));
      if (row_end) batch.push_back(make_result(r - 1, c, (win >> 1) & KEEP_LEFT_COLS));
    end
    if (last_row) begin
      // The bottom row has nothing below it, so its window is the lower two rows moved up.
      up = (win >> 3) & 9'h03F;
      if (c >= 1) batch.push_back(make_result(r, c - 1, up));
      if (row_end) begin
        batch.push_back(make_result(r, c, (up >> 1) & KEEP_LEFT_COLS));
        batch[batch.size() - 1].frame_last = 1'b1;
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
    foreach (batch[i]) owed_results.push_back(batch[i]);
    if (row_end) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  task automatic check_result();
    morph_result_t got;
    morph_result_t want;
    got = {res_if.out_row, res_if.out_col, res_if.out_pixel,
           res_if.run_last, res_if.frame_last};
    checked_o++;
    if (owed_results.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) begin
        $display("[%0t] unexpected result: row %0d col %0d px %0b run_last %0b frame_last %0b",
                 $realtime, got.row, got.col, got.px, got.run_last, got.frame_last);
      end
    end else begin
      want = owed_results.pop_front();
      if (got !== want) begin
        fail_count_o++;
        if (fail_count_o <= 10) begin
          $display("[%0t] mismatch: expected row %0d col %0d px %0b run_last %0b frame_last %0b",
                   $realtime, want.row, want.col, want.px, want.run_last, want.frame_last);
          $display("[%0t]           got row %0d col %0d px %0b run_last %0b frame_last %0b",
                   $realtime, got.row, got.col, got.px, got.run_last, got.frame_last);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width    = CFG_RESET.image_width;
      cfg_height   = CFG_RESET.image_height;
      cfg_op       = CFG_RESET.operation;
      cfg_mask     = CFG_RESET.structuring_mask;
      win          = '0;
      col_cnt      = 0;
      row_cnt      = 0;
      owed_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      // Results leave before the pixel of the same edge is counted in.
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) check_result();
      if (pix_if.valid === 1'b1 && pix_if.ready === 1'b1) morph_pixel(pix_if.pixel_in);
      if (cfg_we_i === 1'b1) begin
        case (bm3_cfg_idx_e'(cfg_idx_i))
          CFG_IMAGE_WIDTH:      cfg_width  = cfg_data_i[10:0];
          CFG_IMAGE_HEIGHT:     cfg_height = cfg_data_i[12:0];
          CFG_OPERATION:        cfg_op     = cfg_data_i[0];
          CFG_STRUCTURING_MASK: cfg_mask   = cfg_data_i[8:0];
          default: ;
        endcase
      end
      pending_o = owed_results.size();
    end
  end

endmodule

### tb/binary_morphology_3x3_tb.sv
`timescale 1ns / 1ps

// Stimulus for the 3x3 binary dilation / erosion block. The checker beside the
// block does all prediction and comparison; this module only feeds pixels,
// throttles the result channel, writes the registers and gives the verdict.
module binary_morphology_3x3_tb;
  import bm3_pkg::*;

  localparam int unsigned MAX_W         = 1024;
  localparam int unsigned MAX_H         = 4096;
  localparam int unsigned RANDOM_PIXELS = 380;
  // Cycles allowed for a pixel that gives no result to leave the pipeline.
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 400;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked;

  int unsigned pixels_sent;
  int unsigned images_done;
  int unsigned random_pixels;
  bit          quiet;
  bit          hold_kick;

  bm3_pixel_if  pix_if ();
  bm3_result_if res_if ();

  binary_morphology_3x3 #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_if     (pix_if),
    .res_if     (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  bm3_morph_checker #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_if       (pix_if),
    .res_if       (res_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Gap lengths for both sides: mostly none, often a short one, now and
  // then a long pause. In a quiet stretch there are no gaps at all.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [8:0] pick_mask();
    case ($urandom_range(0, 5))
      0:       return 9'h000;
      1:       return 9'h1FF;
      2:       return CFG_RESET.structuring_mask;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  // Offers one pixel and returns just after the edge at which the transaction
  // took place. Valid stays high into the next pixel when there is no gap, so
  // it is never lowered and raised within one time step.
  task automatic send_pixel(input logic px);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_if.valid    <= 1'b1;
    pix_if.pixel_in <= px;
    do @(posedge clk_i); while (pix_if.ready !== 1'b1);
    pixels_sent++;
  endtask

  // Stops offering pixels and waits until every owed result has been taken.
  // The extra cycles cover pixels of a first row, which give no result but
  // may still be inside the block when the last result has left.
  task automatic quiesce();
    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input bm3_cfg_idx_e idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input logic op,
                           input logic [8:0] mask);
    quiesce();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_OPERATION, 32'(op));
    write_reg(CFG_STRUCTURING_MASK, 32'(mask));
  endtask

  // One whole image of random pixels at the given density (percent of set
  // pixels). After row mid_row, if it is not the last, the operation and the
  // mask are changed part way through the image; the width is never changed
  // inside an image, so no line store entry is read before it is written.
  task automatic run_image(input int unsigned w, input int unsigned h, input logic op,
                           input logic [8:0] mask, input int unsigned density,
                           input int mid_row);
    int unsigned weff;
    int unsigned heff;
    weff = (w == 0) ? 1 : ((w > MAX_W) ? MAX_W : w);
    heff = (h == 0) ? 1 : ((h > MAX_H) ? MAX_H : h);
    configure(w, h, op, mask);
    for (int unsigned r = 0; r < heff; r++) begin
      for (int unsigned c = 0; c < weff; c++) begin
        send_pixel($urandom_range(0, 99) < density);
      end
      if (r == mid_row && r + 1 < heff) begin
        quiesce();
        write_reg(CFG_OPERATION, $urandom_range(0, 1));
        write_reg(CFG_STRUCTURING_MASK, 32'(pick_mask()));
      end
    end
    images_done++;
  endtask

  // Result side. Ready is dropped for random stretches, and once, when asked
  // to, held low for a long stretch while pixels keep coming, so that the
  // block's queue fills and the pixel input stalls.
  initial begin
    int unsigned stall_left;
    bit          hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_kick && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Safety net against a hung handshake.
  initial begin
    #24_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned img;
    logic [8:0]  small_img;
    pixels_sent   = 0;
    images_done   = 0;
    random_pixels = 0;
    quiet         = 1'b0;
    hold_kick     = 1'b0;
    small_img     = 9'b100010101;
    rst_ni          <= 1'b0;
    pix_if.valid    <= 1'b0;
    pix_if.pixel_in <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_IMAGE_WIDTH;
    cfg_data        <= '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // A small 3x3 image with the cross mask, dilated.
    configure(3, 3, OP_DILATE, CFG_RESET.structuring_mask);
    for (int i = 0; i < 9; i++) send_pixel(small_img[i]);
    images_done++;

    // Zero width and height act as one pixel. With an empty mask erosion
    // gives a set pixel and dilation a clear one.
    configure(0, 0, OP_ERODE, 9'h000);
    send_pixel(1'b0);
    quiesce();
    write_reg(CFG_OPERATION, 32'(OP_DILATE));
    send_pixel(1'b1);
    images_done += 2;

    // Full mask, erosion, all pixels set: the zero border clears every result.
    configure(2, 2, OP_ERODE, 9'h1FF);
    repeat (4) send_pixel(1'b1);
    images_done++;

    // Height beyond the maximum saturates; a column of one pixel then gets its
    // operation and mask changed half way, and finally a smaller height ends
    // the image at once because the row count is already past it.
    configure(1, 8191, OP_DILATE, CFG_RESET.structuring_mask);
    send_pixel(1'b1);
    send_pixel(1'b0);
    send_pixel(1'b1);
    quiesce();
    write_reg(CFG_OPERATION, 32'(OP_ERODE));
    write_reg(CFG_STRUCTURING_MASK, 32'h1FF);
    send_pixel(1'b1);
    quiesce();
    write_reg(CFG_IMAGE_HEIGHT, 2);
    send_pixel(1'b0);
    images_done++;

    // Random images, mostly small. During one of them the result side holds
    // off for a long stretch, starting with its first pixel.
    img = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      img++;
      quiet = ($urandom_range(0, 3) == 0);
      if (img == 4) begin
        quiet = 1'b0;
        fork
          begin
            @(posedge clk_i iff (pix_if.valid === 1'b1 && pix_if.ready === 1'b1));
            hold_kick = 1'b1;
          end
        join_none
        run_image(16, 3, 1'($urandom_range(0, 1)), pick_mask(), $urandom_range(10, 90), -1);
        random_pixels += 48;
      end else begin
        w = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(9, 24);
        h = $urandom_range(0, 6);
        run_image(w, h, 1'($urandom_range(0, 1)), pick_mask(), $urandom_range(0, 100),
                  ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4)) : -1);
        random_pixels += ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      end
    end

    quiet = 1'b0;
    quiesce();
    repeat (20) @(negedge clk_i);

    $display("Run covered %0d pixels in %0d images: dilation and erosion, empty and full masks,",
             pixels_sent, images_done);
    $display("degenerate and saturated sizes, mid-image writes; %0d results compared.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
